>>> sv/ocsc_pkg.sv
// Shared constants and controller/datapath types for the occluded column span clipper.
package ocsc_pkg;

  localparam int MAX_RANGES_DEF  = 32;
  localparam int COLUMN_BITS_DEF = 13;
  localparam int SCREEN_W        = 13;
  localparam logic [SCREEN_W-1:0] SCREEN_RESET = SCREEN_W'(320);

  typedef enum logic [2:0] {
    WR_READ,
    WR_SPAN,
    WR_MERGE,
    WR_LEFT,
    WR_RIGHT
  } wr_sel_t;

  typedef struct packed {
    logic    start;
    logic    rd_en;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    consume;
    logic    gap_en;
    logic    take_f;
    logic    take_l;
    logic    flush;
    logic    ovf;
  } ocsc_cmd_t;

  typedef struct packed {
    logic req_span;
    logic reversed;
    logic solid;
    logic hit_f;
    logic hit_l;
    logic stall;
    logic out_free;
  } ocsc_stat_t;

endpackage

>>> sv/ocsc_in_if.sv
// Span request channel carrying valid, ready and the request payload.
interface ocsc_in_if import ocsc_pkg::*; #(
  parameter int COL_W = COLUMN_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [COL_W-1:0] first_column;
  logic signed [COL_W-1:0] last_column;
  logic                    is_solid;

  modport source (output valid, req_type, first_column, last_column, is_solid, input ready);
  modport sink (input valid, req_type, first_column, last_column, is_solid, output ready);
endinterface

>>> sv/ocsc_out_if.sv
// Visible sub-span result channel carrying valid, ready and the result payload.
interface ocsc_out_if import ocsc_pkg::*; #(
  parameter int COL_W = COLUMN_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic                    visible;
  logic signed [COL_W-1:0] span_first;
  logic signed [COL_W-1:0] span_last;
  logic                    last_of_run;
  logic                    store_overflow;

  modport source (output valid, visible, span_first, span_last, last_of_run, store_overflow,
                  input ready);
  modport sink (input valid, visible, span_first, span_last, last_of_run, store_overflow,
                output ready);
endinterface

>>> sv/occluded_column_span_clipper.sv
// Top level of the occluded column span clipper: controller, datapath and channel wiring.
//
//   Channel   Direction  Handshake        Payload
//   in_ch     sink       valid / ready    req_type, first_column, last_column, is_solid
//   out_ch    source     valid / ready    visible, span_first, span_last, last_of_run,
//                                         store_overflow
//   cfg       sink       cfg_we           cfg_wdata (screen_columns)
//
// A span is accepted in S_IDLE, walks the list in S_SCAN, gives its final result in S_FLUSH and
// then updates the list in the insert or merge states, all through the single read and single
// write port of the range store. A frame start clears the list in S_CLR0 and S_CLR1.
// After reset, S_CLR0 and S_CLR1 write the two sentinel entries before a transaction is taken.
// The walk pauses while a second visible sub-span is found and the result register is held.
module occluded_column_span_clipper import ocsc_pkg::*; #(
  parameter int MAX_RANGES  = MAX_RANGES_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ocsc_in_if.sink             in_ch,
  ocsc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [SCREEN_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_RANGES);

  ocsc_cmd_t        cmd;
  ocsc_stat_t       stat;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  ocsc_ctrl #(
    .MAX_RANGES (MAX_RANGES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  ocsc_dp #(
    .MAX_RANGES  (MAX_RANGES),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .wr_addr            (wr_addr),
    .stat               (stat),
    .in_req_type        (in_ch.req_type),
    .in_first_column    (in_ch.first_column),
    .in_last_column     (in_ch.last_column),
    .in_is_solid        (in_ch.is_solid),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_visible        (out_ch.visible),
    .out_span_first     (out_ch.span_first),
    .out_span_last      (out_ch.span_last),
    .out_last_of_run    (out_ch.last_of_run),
    .out_store_overflow (out_ch.store_overflow)
  );

endmodule

>>> sv/ocsc_dp.sv
// Datapath: range store, gap and overlap arithmetic, pending sub-span and result register.
module ocsc_dp import ocsc_pkg::*; #(
  parameter int MAX_RANGES  = MAX_RANGES_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ocsc_cmd_t                     cmd,
  input  logic [$clog2(MAX_RANGES)-1:0] rd_addr,
  input  logic [$clog2(MAX_RANGES)-1:0] wr_addr,
  output ocsc_stat_t                    stat,
  input  logic                          in_req_type,
  input  logic signed [COLUMN_BITS-1:0] in_first_column,
  input  logic signed [COLUMN_BITS-1:0] in_last_column,
  input  logic                          in_is_solid,
  input  logic                          cfg_we,
  input  logic [SCREEN_W-1:0]           cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_visible,
  output logic signed [COLUMN_BITS-1:0] out_span_first,
  output logic signed [COLUMN_BITS-1:0] out_span_last,
  output logic                          out_last_of_run,
  output logic                          out_store_overflow
);

  localparam int CB = COLUMN_BITS;
  localparam int SW = ((COLUMN_BITS > SCREEN_W) ? COLUMN_BITS : SCREEN_W) + 1;
  localparam int XW = SW + 1;
  localparam logic signed [XW-1:0] ONE_X = XW'(1);
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_NEG1 = {SW{1'b1}};

  logic [2*SW-1:0] mem [MAX_RANGES];
  logic [2*SW-1:0] rd_data_r;
  logic [2*SW-1:0] wr_data;

  logic signed [CB-1:0] a_r, b_r;
  logic [SW-1:0]        prev_hi_r, low_f_r, high_l_r;
  logic [CB-1:0]        pend_lo_r, pend_hi_r;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [SCREEN_W-1:0]  scr_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_vis_r, out_lor_r, out_ovf_r;
  logic [CB-1:0]        out_first_r, out_last_r;

  logic [SW-1:0]        ent_lo, ent_hi;
  logic signed [XW-1:0] lo_x, hi_x, prev_x, a_x, b_x;
  logic signed [XW-1:0] glo_raw, ghi_raw, glo, ghi;
  logic signed [SW-1:0] a_s, b_s, lowf_s, highl_s, mrg_lo, mrg_hi;
  logic                 gap_ne, out_free, push_pend, out_load;

  assign ent_lo = rd_data_r[2*SW-1:SW];
  assign ent_hi = rd_data_r[SW-1:0];
  assign lo_x   = {ent_lo[SW-1], ent_lo};
  assign hi_x   = {ent_hi[SW-1], ent_hi};
  assign prev_x = {prev_hi_r[SW-1], prev_hi_r};
  assign a_x    = {{(XW-CB){a_r[CB-1]}}, a_r};
  assign b_x    = {{(XW-CB){b_r[CB-1]}}, b_r};

  assign glo_raw = prev_x + ONE_X;
  assign ghi_raw = lo_x - ONE_X;
  assign glo     = (glo_raw < a_x) ? a_x : glo_raw;
  assign ghi     = (ghi_raw > b_x) ? b_x : ghi_raw;
  assign gap_ne  = (glo <= ghi);

  assign out_free  = !out_valid_r || out_ready;
  assign push_pend = cmd.gap_en && gap_ne && pend_valid_r;
  assign out_load  = push_pend || cmd.flush;

  assign stat.req_span = in_req_type;
  assign stat.reversed = (in_first_column > in_last_column);
  assign stat.solid    = in_is_solid;
  assign stat.hit_f    = (hi_x >= (a_x - ONE_X));
  assign stat.hit_l    = (lo_x <= (b_x + ONE_X));
  assign stat.stall    = gap_ne && pend_valid_r && !out_free;
  assign stat.out_free = out_free;

  assign a_s     = {{(SW-CB){a_r[CB-1]}}, a_r};
  assign b_s     = {{(SW-CB){b_r[CB-1]}}, b_r};
  assign lowf_s  = low_f_r;
  assign highl_s = high_l_r;
  assign mrg_lo  = (lowf_s > a_s) ? a_s : lowf_s;
  assign mrg_hi  = (highl_s > b_s) ? highl_s : b_s;

  always_comb begin
    case (cmd.wr_sel)
      WR_READ:  wr_data = rd_data_r;
      WR_SPAN:  wr_data = {a_s, b_s};
      WR_MERGE: wr_data = {mrg_lo, mrg_hi};
      WR_LEFT:  wr_data = {S_MIN, S_NEG1};
      WR_RIGHT: wr_data = {{(SW-SCREEN_W){1'b0}}, scr_r, S_MAX};
      default:  wr_data = rd_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= in_first_column;
      b_r <= in_last_column;
    end
    if (cmd.consume) begin
      prev_hi_r <= ent_hi;
    end
    if (cmd.take_f) begin
      low_f_r <= ent_lo;
    end
    if (cmd.take_l) begin
      high_l_r <= ent_hi;
    end
    if (cmd.gap_en && gap_ne) begin
      pend_lo_r <= glo[CB-1:0];
      pend_hi_r <= ghi[CB-1:0];
    end
    if (out_load) begin
      if (cmd.flush) begin
        out_vis_r   <= pend_valid_r;
        out_first_r <= pend_valid_r ? pend_lo_r : '0;
        out_last_r  <= pend_valid_r ? pend_hi_r : '0;
        out_lor_r   <= 1'b1;
        out_ovf_r   <= cmd.ovf;
      end else begin
        out_vis_r   <= 1'b1;
        out_first_r <= pend_lo_r;
        out_last_r  <= pend_hi_r;
        out_lor_r   <= 1'b0;
        out_ovf_r   <= 1'b0;
      end
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.start || cmd.flush) begin
      pend_valid_nxt = 1'b0;
    end else if (cmd.gap_en && gap_ne) begin
      pend_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scr_r        <= SCREEN_RESET;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        scr_r <= cfg_wdata;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_visible        = out_vis_r;
  assign out_span_first     = out_first_r;
  assign out_span_last      = out_last_r;
  assign out_last_of_run    = out_lor_r;
  assign out_store_overflow = out_ovf_r;

endmodule

>>> sv/ocsc_ctrl.sv
// Controller: sequences list clearing, the range walk, the final result and the list update.
module ocsc_ctrl import ocsc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ocsc_stat_t                    stat,
  output ocsc_cmd_t                     cmd,
  output logic [$clog2(MAX_RANGES)-1:0] rd_addr,
  output logic [$clog2(MAX_RANGES)-1:0] wr_addr
);

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CW    = $clog2(MAX_RANGES + 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLR0      = 9'b000000010,
    S_CLR1      = 9'b000000100,
    S_SCAN      = 9'b000001000,
    S_FLUSH     = 9'b000010000,
    S_INS_SHIFT = 9'b000100000,
    S_INS_PUT   = 9'b001000000,
    S_MRG_PUT   = 9'b010000000,
    S_MRG_SHIFT = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt, issue_r, issue_nxt;
  logic             span_r, span_nxt, rev_r, rev_nxt, merge_r, merge_nxt;
  logic             proc_valid_r, proc_valid_nxt, f_found_r, f_found_nxt;
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt, f_r, f_nxt, l_r, l_nxt;
  logic [IDX_W-1:0] sh_r, sh_nxt, waddr_r, waddr_nxt;
  logic             wpend_r, wpend_nxt, rdone_r, rdone_nxt;

  logic [IDX_W-1:0] drop;
  logic [CW-1:0]    cnt_last;
  logic             full, no_touch, blocked;

  assign drop     = l_r - f_r;
  assign cnt_last = cnt_r - CW'(1);
  assign full     = (cnt_r == CW'(MAX_RANGES));
  assign no_touch = (f_r > l_r);
  assign blocked  = proc_valid_r && (proc_idx_r != '0) && stat.stall;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_nxt      = issue_r;
    span_nxt       = span_r;
    rev_nxt        = rev_r;
    merge_nxt      = merge_r;
    proc_valid_nxt = proc_valid_r;
    proc_idx_nxt   = proc_idx_r;
    f_found_nxt    = f_found_r;
    f_nxt          = f_r;
    l_nxt          = l_r;
    sh_nxt         = sh_r;
    waddr_nxt      = waddr_r;
    wpend_nxt      = wpend_r;
    rdone_nxt      = rdone_r;
    cmd            = '0;
    cmd.wr_sel     = WR_READ;
    rd_addr        = '0;
    wr_addr        = '0;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        issue_nxt      = '0;
        proc_valid_nxt = 1'b0;
        f_found_nxt    = 1'b0;
        f_nxt          = '0;
        l_nxt          = '0;
        if (in_valid) begin
          span_nxt = stat.req_span;
          rev_nxt  = stat.reversed;
          if (!stat.req_span) begin
            state_nxt = S_CLR0;
          end else begin
            cmd.start = 1'b1;
            merge_nxt = stat.solid && !stat.reversed;
            if (cnt_r < CW'(2)) begin
              state_nxt = S_CLR0;
            end else if (stat.reversed) begin
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_CLR0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LEFT;
        wr_addr    = '0;
        state_nxt  = S_CLR1;
      end
      S_CLR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RIGHT;
        wr_addr    = IDX_W'(1);
        cnt_nxt    = CW'(2);
        if (!span_r) begin
          state_nxt = S_IDLE;
        end else if (rev_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!blocked) begin
          if (proc_valid_r) begin
            cmd.consume = 1'b1;
            cmd.gap_en  = (proc_idx_r != '0);
            cmd.take_l  = stat.hit_l;
            if (stat.hit_l) begin
              l_nxt = proc_idx_r;
            end
            if (stat.hit_f && !f_found_r) begin
              cmd.take_f  = 1'b1;
              f_nxt       = proc_idx_r;
              f_found_nxt = 1'b1;
            end
          end
          if (issue_r < cnt_r) begin
            cmd.rd_en      = 1'b1;
            rd_addr        = issue_r[IDX_W-1:0];
            issue_nxt      = issue_r + CW'(1);
            proc_valid_nxt = 1'b1;
            proc_idx_nxt   = issue_r[IDX_W-1:0];
          end else begin
            proc_valid_nxt = 1'b0;
            if (!proc_valid_r) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          cmd.ovf   = merge_r && no_touch && full;
          if (!merge_r) begin
            state_nxt = S_IDLE;
          end else if (no_touch) begin
            if (full) begin
              state_nxt = S_IDLE;
            end else begin
              sh_nxt    = cnt_last[IDX_W-1:0];
              rdone_nxt = 1'b0;
              wpend_nxt = 1'b0;
              state_nxt = S_INS_SHIFT;
            end
          end else begin
            state_nxt = S_MRG_PUT;
          end
        end
      end
      S_INS_SHIFT: begin
        if (wpend_r) begin
          cmd.wr_en = 1'b1;
          wr_addr   = waddr_r;
        end
        if (!rdone_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = sh_r;
          wpend_nxt = 1'b1;
          waddr_nxt = sh_r + IDX_W'(1);
          if (sh_r == f_r) begin
            rdone_nxt = 1'b1;
          end else begin
            sh_nxt = sh_r - IDX_W'(1);
          end
        end else begin
          wpend_nxt = 1'b0;
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SPAN;
        wr_addr    = f_r;
        cnt_nxt    = cnt_r + CW'(1);
        state_nxt  = S_IDLE;
      end
      S_MRG_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MERGE;
        wr_addr    = f_r;
        if ((drop == '0) || (CW'(l_r) == cnt_last)) begin
          cnt_nxt   = cnt_r - CW'(drop);
          state_nxt = S_IDLE;
        end else begin
          sh_nxt    = l_r + IDX_W'(1);
          rdone_nxt = 1'b0;
          wpend_nxt = 1'b0;
          state_nxt = S_MRG_SHIFT;
        end
      end
      S_MRG_SHIFT: begin
        if (wpend_r) begin
          cmd.wr_en = 1'b1;
          wr_addr   = waddr_r;
        end
        if (!rdone_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = sh_r;
          wpend_nxt = 1'b1;
          waddr_nxt = sh_r - drop;
          if (CW'(sh_r) == cnt_last) begin
            rdone_nxt = 1'b1;
          end else begin
            sh_nxt = sh_r + IDX_W'(1);
          end
        end else begin
          wpend_nxt = 1'b0;
          cnt_nxt   = cnt_r - CW'(drop);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR0;
      cnt_r        <= CW'(2);
      issue_r      <= '0;
      span_r       <= 1'b0;
      rev_r        <= 1'b0;
      merge_r      <= 1'b0;
      proc_valid_r <= 1'b0;
      proc_idx_r   <= '0;
      f_found_r    <= 1'b0;
      f_r          <= '0;
      l_r          <= '0;
      sh_r         <= '0;
      waddr_r      <= '0;
      wpend_r      <= 1'b0;
      rdone_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      issue_r      <= issue_nxt;
      span_r       <= span_nxt;
      rev_r        <= rev_nxt;
      merge_r      <= merge_nxt;
      proc_valid_r <= proc_valid_nxt;
      proc_idx_r   <= proc_idx_nxt;
      f_found_r    <= f_found_nxt;
      f_r          <= f_nxt;
      l_r          <= l_nxt;
      sh_r         <= sh_nxt;
      waddr_r      <= waddr_nxt;
      wpend_r      <= wpend_nxt;
      rdone_r      <= rdone_nxt;
    end
  end

endmodule
